// File: hdl/jepp_pkg.sv
// Shared types, constants and literal tables for the envelope prefix peek unit.
`default_nettype none

package jepp_pkg;

    localparam int BYTE_W         = 8;
    localparam int OP_W           = 10;
    localparam int SEQ_W          = 63;
    localparam int OFS_W          = 3;
    localparam int DIGIT_W        = 4;
    localparam int RES_FIFO_DEPTH = 4;

    localparam logic [OP_W-1:0] OP_LIMIT = OP_W'(99);

    localparam logic [BYTE_W-1:0] CH_QUOTE = "\"";
    localparam logic [BYTE_W-1:0] CH_COMMA = ",";
    localparam logic [BYTE_W-1:0] CH_N     = "n";

    typedef enum logic [3:0] {
        PH_PRE, PH_TVAL, PH_TNULL, PH_NAME0, PH_NAME, PH_SLIT, PH_SVAL,
        PH_SNULL, PH_SDIG, PH_OLIT, PH_ODIG0, PH_ODIG, PH_DONE, PH_DEAD
    } phase_t;

    typedef enum logic [1:0] {
        LIT_PRE, LIT_S, LIT_OP, LIT_NULL
    } lit_sel_t;

    typedef enum logic {
        KIND_NAME    = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   name_char;
        logic                matched;
        logic [OP_W-1:0]     opcode;
        logic                has_seq;
        logic [SEQ_W-1:0]    seq_number;
        logic                has_event;
        logic                end_of_run;
    } result_t;

    // up to two results per accepted byte: name byte first, then verdict
    typedef struct packed {
        logic    push_name;
        logic    push_verdict;
        result_t name_res;
        result_t verdict_res;
    } push_t;

    function automatic logic [OFS_W-1:0] lit_len(lit_sel_t sel);
        logic [OFS_W-1:0] len;
        unique case (sel)
            LIT_PRE:  len = OFS_W'(5);
            LIT_S:    len = OFS_W'(5);
            LIT_OP:   len = OFS_W'(6);
            LIT_NULL: len = OFS_W'(4);
            default:  len = OFS_W'(4);
        endcase
        return len;
    endfunction

    // literal byte at a given offset; offsets past the end never match a length check
    function automatic logic [BYTE_W-1:0] lit_char(lit_sel_t sel, logic [OFS_W-1:0] ofs);
        logic [BYTE_W-1:0] ch;
        ch = '0;
        unique case (sel)
            LIT_PRE:
            begin
                case (ofs)
                    3'd0:    ch = "{";
                    3'd1:    ch = "\"";
                    3'd2:    ch = "t";
                    3'd3:    ch = "\"";
                    3'd4:    ch = ":";
                    default: ch = '0;
                endcase
            end
            LIT_S:
            begin
                case (ofs)
                    3'd0:    ch = ",";
                    3'd1:    ch = "\"";
                    3'd2:    ch = "s";
                    3'd3:    ch = "\"";
                    3'd4:    ch = ":";
                    default: ch = '0;
                endcase
            end
            LIT_OP:
            begin
                case (ofs)
                    3'd0:    ch = ",";
                    3'd1:    ch = "\"";
                    3'd2:    ch = "o";
                    3'd3:    ch = "p";
                    3'd4:    ch = "\"";
                    3'd5:    ch = ":";
                    default: ch = '0;
                endcase
            end
            LIT_NULL:
            begin
                case (ofs)
                    3'd0:    ch = "n";
                    3'd1:    ch = "u";
                    3'd2:    ch = "l";
                    3'd3:    ch = "l";
                    default: ch = '0;
                endcase
            end
            default: ch = '0;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(logic [BYTE_W-1:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic name_ok(logic [BYTE_W-1:0] c);
        return ((c >= "A") && (c <= "Z")) || (c == "_") || is_digit(c);
    endfunction

endpackage

`default_nettype wire

// File: hdl/jepp_parser.sv
// Per-byte prefix parser: state registers plus the single-pass next-state logic.
`default_nettype none

module jepp_parser
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic [jepp_pkg::BYTE_W-1:0]   byte_in,
    input  wire logic                          last_in,
    output jepp_pkg::push_t                    push
);

    localparam int SEQ_W  = jepp_pkg::SEQ_W;
    localparam int OP_W   = jepp_pkg::OP_W;
    localparam int OFS_W  = jepp_pkg::OFS_W;
    localparam int PROD_W = SEQ_W + 4;

    jepp_pkg::phase_t       phase_reg, phase_next, phase_upd;
    logic [OFS_W-1:0]       ofs_reg, ofs_next, ofs_upd;
    logic [SEQ_W-1:0]       seq_acc_reg, seq_acc_next, seq_acc_upd;
    logic                   seq_present_reg, seq_present_next, seq_present_upd;
    logic                   event_present_reg, event_present_next, event_present_upd;
    logic [OP_W-1:0]        op_acc_reg, op_acc_next, op_acc_upd;

    logic [jepp_pkg::DIGIT_W-1:0] digit;
    logic [PROD_W-1:0]      seq_prod;
    logic                   seq_ovf;
    logic [OP_W-1:0]        op_prod;

    jepp_pkg::lit_sel_t     lit_sel;
    jepp_pkg::phase_t       lit_target;
    logic                   is_lit;
    logic [OFS_W-1:0]       lit_ofs_inc;

    logic                   ok;
    logic                   name_hit;
    logic                   verdict_now;
    logic                   verdict_push;
    logic                   verdict_match;

    assign digit    = jepp_pkg::DIGIT_W'(byte_in - 8'h30);
    // seq * 10 + d, checked against 2^63-1 by the carry bits
    assign seq_prod = (PROD_W'(seq_acc_reg) << 3) + (PROD_W'(seq_acc_reg) << 1)
                    + PROD_W'(digit);
    assign seq_ovf  = |seq_prod[PROD_W-1:SEQ_W];
    assign op_prod  = (op_acc_reg << 3) + (op_acc_reg << 1) + OP_W'(digit);
    assign lit_ofs_inc = ofs_reg + OFS_W'(1);

    // literal phases
    always_comb
    begin
        is_lit     = 1'b1;
        lit_sel    = jepp_pkg::LIT_PRE;
        lit_target = jepp_pkg::PH_TVAL;
        unique case (phase_reg)
            jepp_pkg::PH_PRE:
            begin
                lit_sel    = jepp_pkg::LIT_PRE;
                lit_target = jepp_pkg::PH_TVAL;
            end
            jepp_pkg::PH_TNULL:
            begin
                lit_sel    = jepp_pkg::LIT_NULL;
                lit_target = jepp_pkg::PH_SLIT;
            end
            jepp_pkg::PH_SLIT:
            begin
                lit_sel    = jepp_pkg::LIT_S;
                lit_target = jepp_pkg::PH_SVAL;
            end
            jepp_pkg::PH_SNULL:
            begin
                lit_sel    = jepp_pkg::LIT_NULL;
                lit_target = jepp_pkg::PH_OLIT;
            end
            jepp_pkg::PH_OLIT:
            begin
                lit_sel    = jepp_pkg::LIT_OP;
                lit_target = jepp_pkg::PH_ODIG0;
            end
            default: is_lit = 1'b0;
        endcase
    end

    // next state for one byte
    always_comb
    begin
        phase_upd         = phase_reg;
        ofs_upd           = ofs_reg;
        seq_acc_upd       = seq_acc_reg;
        seq_present_upd   = seq_present_reg;
        event_present_upd = event_present_reg;
        op_acc_upd        = op_acc_reg;
        ok                = 1'b1;
        name_hit          = 1'b0;
        verdict_now       = 1'b0;

        if (is_lit)
        begin
            if ((ofs_reg < jepp_pkg::lit_len(lit_sel))
                && (byte_in == jepp_pkg::lit_char(lit_sel, ofs_reg)))
            begin
                if (lit_ofs_inc == jepp_pkg::lit_len(lit_sel))
                begin
                    phase_upd = lit_target;
                    ofs_upd   = '0;
                end
                else
                begin
                    ofs_upd = lit_ofs_inc;
                end
            end
            else
            begin
                ok = 1'b0;
            end
        end
        else
        begin
            unique case (phase_reg) inside
                jepp_pkg::PH_TVAL:
                begin
                    if (byte_in == jepp_pkg::CH_N)
                    begin
                        phase_upd = jepp_pkg::PH_TNULL;
                        ofs_upd   = OFS_W'(1);
                    end
                    else if (byte_in == jepp_pkg::CH_QUOTE)
                        phase_upd = jepp_pkg::PH_NAME0;
                    else
                        ok = 1'b0;
                end
                jepp_pkg::PH_NAME0, jepp_pkg::PH_NAME:
                begin
                    if (jepp_pkg::name_ok(byte_in))
                    begin
                        name_hit  = 1'b1;
                        phase_upd = jepp_pkg::PH_NAME;
                    end
                    else if ((byte_in == jepp_pkg::CH_QUOTE)
                             && (phase_reg == jepp_pkg::PH_NAME))
                    begin
                        event_present_upd = 1'b1;
                        phase_upd         = jepp_pkg::PH_SLIT;
                        ofs_upd           = '0;
                    end
                    else
                        ok = 1'b0;
                end
                jepp_pkg::PH_SVAL:
                begin
                    if (byte_in == jepp_pkg::CH_N)
                    begin
                        phase_upd = jepp_pkg::PH_SNULL;
                        ofs_upd   = OFS_W'(1);
                    end
                    else if (jepp_pkg::is_digit(byte_in))
                    begin
                        seq_acc_upd = SEQ_W'(digit);
                        phase_upd   = jepp_pkg::PH_SDIG;
                    end
                    else
                        ok = 1'b0;
                end
                jepp_pkg::PH_SDIG:
                begin
                    if (jepp_pkg::is_digit(byte_in))
                    begin
                        if (seq_ovf)
                            ok = 1'b0;
                        else
                            seq_acc_upd = seq_prod[SEQ_W-1:0];
                    end
                    else if (byte_in == jepp_pkg::CH_COMMA)
                    begin
                        // comma already consumed: resume op literal past it
                        seq_present_upd = 1'b1;
                        phase_upd       = jepp_pkg::PH_OLIT;
                        ofs_upd         = OFS_W'(1);
                    end
                    else
                        ok = 1'b0;
                end
                jepp_pkg::PH_ODIG0:
                begin
                    if (jepp_pkg::is_digit(byte_in))
                    begin
                        op_acc_upd = OP_W'(digit);
                        phase_upd  = jepp_pkg::PH_ODIG;
                    end
                    else
                        ok = 1'b0;
                end
                jepp_pkg::PH_ODIG:
                begin
                    if (jepp_pkg::is_digit(byte_in))
                    begin
                        if (op_acc_reg > jepp_pkg::OP_LIMIT)
                            ok = 1'b0;
                        else
                            op_acc_upd = op_prod;
                    end
                    else
                    begin
                        verdict_now = 1'b1;
                        phase_upd   = jepp_pkg::PH_DONE;
                    end
                end
                jepp_pkg::PH_DONE: ;
                default: ok = 1'b0;
            endcase
        end

        if (!ok)
        begin
            phase_upd = jepp_pkg::PH_DEAD;
            ofs_upd   = '0;
        end
    end

    assign verdict_push  = verdict_now
                        || (last_in && (phase_upd != jepp_pkg::PH_DONE));
    assign verdict_match = verdict_now || (phase_upd == jepp_pkg::PH_ODIG);

    // result words
    always_comb
    begin
        push = '0;
        push.push_name            = fire && name_hit;
        push.push_verdict         = fire && verdict_push;
        push.name_res.kind        = jepp_pkg::KIND_NAME;
        push.name_res.name_char   = byte_in;
        push.name_res.end_of_run  = !verdict_push;
        push.verdict_res.kind     = jepp_pkg::KIND_VERDICT;
        push.verdict_res.end_of_run = 1'b1;
        if (verdict_match)
        begin
            push.verdict_res.matched    = 1'b1;
            push.verdict_res.opcode     = op_acc_upd;
            push.verdict_res.has_seq    = seq_present_upd;
            push.verdict_res.seq_number = seq_present_upd ? seq_acc_upd : '0;
            push.verdict_res.has_event  = event_present_upd;
        end
    end

    // last byte re-arms
    always_comb
    begin
        phase_next         = phase_reg;
        ofs_next           = ofs_reg;
        seq_acc_next       = seq_acc_reg;
        seq_present_next   = seq_present_reg;
        event_present_next = event_present_reg;
        op_acc_next        = op_acc_reg;
        if (fire)
        begin
            if (last_in)
            begin
                phase_next         = jepp_pkg::PH_PRE;
                ofs_next           = '0;
                seq_acc_next       = '0;
                seq_present_next   = 1'b0;
                event_present_next = 1'b0;
                op_acc_next        = '0;
            end
            else
            begin
                phase_next         = phase_upd;
                ofs_next           = ofs_upd;
                seq_acc_next       = seq_acc_upd;
                seq_present_next   = seq_present_upd;
                event_present_next = event_present_upd;
                op_acc_next        = op_acc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= jepp_pkg::PH_PRE;
            ofs_reg           <= '0;
            seq_acc_reg       <= '0;
            seq_present_reg   <= 1'b0;
            event_present_reg <= 1'b0;
            op_acc_reg        <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            ofs_reg           <= ofs_next;
            seq_acc_reg       <= seq_acc_next;
            seq_present_reg   <= seq_present_next;
            event_present_reg <= event_present_next;
            op_acc_reg        <= op_acc_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/jepp_result_fifo.sv
// Result queue: takes up to two words per cycle, hands out one while the output is not stalled.
`default_nettype none

module jepp_result_fifo
#(
    parameter int DEPTH = jepp_pkg::RES_FIFO_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire jepp_pkg::push_t  push,
    output logic                  room,
    output jepp_pkg::result_t     head,
    output logic                  head_valid,
    input  wire logic             pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jepp_pkg::result_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [PTR_W-1:0]   verdict_ptr;
    logic [CNT_W-1:0]   n_push;
    logic               pop_fire;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_ptr_inc  = ptr_inc(wr_ptr_reg);
    assign verdict_ptr = push.push_name ? wr_ptr_inc : wr_ptr_reg;
    assign n_push      = CNT_W'(push.push_name) + CNT_W'(push.push_verdict);
    assign pop_fire    = pop && head_valid;

    assign head_valid  = (count_reg != '0);
    assign head        = mem_reg[rd_ptr_reg];
    // two free slots needed before the next byte
    assign room        = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.push_name && push.push_verdict)
            wr_ptr_next = ptr_inc(wr_ptr_inc);
        else if (push.push_name || push.push_verdict)
            wr_ptr_next = wr_ptr_inc;
        rd_ptr_next = pop_fire ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + n_push - CNT_W'(pop_fire);
    end

    always_ff @(posedge clk)
    begin
        if (push.push_name)
            mem_reg[wr_ptr_reg] <= push.name_res;
        if (push.push_verdict)
            mem_reg[verdict_ptr] <= push.verdict_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/json_envelope_prefix_peek_unit.sv
// Top level of the JSON envelope prefix peek unit.
//
//  channel | direction | handshake          | word contents
//  --------+-----------+--------------------+----------------------------------------
//  in      | sink      | in_valid/in_stall  | byte_req, last
//  out     | source    | out_valid/out_stall| kind, name_char, matched, opcode,
//          |           |                    | has_seq, seq_number, has_event, end_of_run
//
// One input word is taken per cycle while in_stall is low; the parser updates
// its state in the same cycle and writes zero, one or two result words into a
// small result queue, which hands out the name word and the verdict of one byte in turn.
// in_stall rises when the queue has fewer than two free slots, so the input
// side keeps running while the output side is stalled until the queue fills.
// Reset clears the parser state and the queue; the first word can be taken
// in the cycle after reset is released.
`default_nettype none

module json_envelope_prefix_peek_unit
#(
    parameter int RES_FIFO_DEPTH = jepp_pkg::RES_FIFO_DEPTH
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [jepp_pkg::BYTE_W-1:0]   byte_req,
    input  wire logic                          last,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               kind,
    output logic [jepp_pkg::BYTE_W-1:0]        name_char,
    output logic                               matched,
    output logic [jepp_pkg::OP_W-1:0]          opcode,
    output logic                               has_seq,
    output logic [jepp_pkg::SEQ_W-1:0]         seq_number,
    output logic                               has_event,
    output logic                               end_of_run
);

    logic               room;
    logic               fire;
    jepp_pkg::push_t    push;
    jepp_pkg::result_t  head;

    assign in_stall = !room;
    assign fire     = in_valid && room;

    jepp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .byte_in (byte_req),
        .last_in (last),
        .push    (push)
    );

    jepp_result_fifo
    #(
        .DEPTH (RES_FIFO_DEPTH)
    )
    u_result_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head       (head),
        .head_valid (out_valid),
        .pop        (!out_stall)
    );

    // unpack head word onto the ports
    assign kind       = head.kind;
    assign name_char  = head.name_char;
    assign matched    = head.matched;
    assign opcode     = head.opcode;
    assign has_seq    = head.has_seq;
    assign seq_number = head.seq_number;
    assign has_event  = head.has_event;
    assign end_of_run = head.end_of_run;

endmodule

`default_nettype wire

// File: tb/json_envelope_prefix_peek_unit_tb.sv
// Testbench for the JSON envelope prefix peek unit: directed and random payloads against a predictor.
`timescale 1ns / 1ps

module json_envelope_prefix_peek_unit_tb;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam int          RANDOM_ITEMS = 450;   // random bytes to feed, not counting those past a verdict
    localparam int          QUIET_LIMIT  = 2000;  // cycles with no word moving on either side
    localparam int          IDLE_PCT     = 27;    // idle / stall chance per cycle, in percent
    localparam int          TAIL_CYCLES  = 16;    // settle time once nothing is owed
    localparam int          MAX_REPORTS  = 10;
    localparam logic [63:0] SEQ_CEIL     = 64'h7FFF_FFFF_FFFF_FFFF;

    // fixed envelope text, right-justified; byte at offset o sits at [8*(len-1-o) +: 8]
    localparam logic [47:0] TAG_T    = "{\"t\":";
    localparam logic [47:0] TAG_S    = ",\"s\":";
    localparam logic [47:0] TAG_OP   = ",\"op\":";
    localparam logic [47:0] TAG_NULL = "null";

    // one row of the directed table; pinned rows carry a verdict typed in by hand
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       pinned;
        logic       pin_matched;
        logic [9:0] pin_opcode;
    } probe_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           in_valid   = 1'b0;
    logic                           in_stall;
    logic [jepp_pkg::BYTE_W-1:0]    byte_req   = '0;
    logic                           last       = 1'b0;
    logic                           out_valid;
    logic                           out_stall  = 1'b0;
    logic                           kind;
    logic [jepp_pkg::BYTE_W-1:0]    name_char;
    logic                           matched;
    logic [jepp_pkg::OP_W-1:0]      opcode;
    logic                           has_seq;
    logic [jepp_pkg::SEQ_W-1:0]     seq_number;
    logic                           has_event;
    logic                           end_of_run;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the parser
    // ------------------------------------------------------------------
    jepp_pkg::phase_t           env_phase   = jepp_pkg::PH_PRE;
    int                         env_ofs     = 0;
    logic [63:0]                env_seq     = '0;
    bit                         env_has_seq = 1'b0;
    bit                         env_named   = 1'b0;
    logic [jepp_pkg::OP_W-1:0]  env_op      = '0;

    jepp_pkg::result_t    byte_words[$];    // words caused by the byte just parsed
    jepp_pkg::result_t    owed_words[$];    // words the DUT still has to deliver, oldest first
    logic [7:0]           frame_q[$];       // payload being built for the random part
    probe_t               probes [0:27];

    jepp_pkg::result_t    got_word;
    jepp_pkg::result_t    want_word;
    int                   faults      = 0;
    int                   items_fed   = 0;
    int                   frames_done = 0;
    int                   quiet       = 0;
    bit                   calm        = 1'b0;   // no idling on either side while set

    json_envelope_prefix_peek_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_req   (byte_req),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .name_char  (name_char),
        .matched    (matched),
        .opcode     (opcode),
        .has_seq    (has_seq),
        .seq_number (seq_number),
        .has_event  (has_event),
        .end_of_run (end_of_run)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Match one byte of a fixed tag at the current offset; moves on to nxt when done.
    function automatic bit tag_step(input logic [47:0] tag, input int len,
                                    input logic [7:0] b, input jepp_pkg::phase_t nxt);
        if (env_ofs >= len || tag[8*(len-1-env_ofs) +: 8] != b)
            return 1'b0;
        if (env_ofs == len - 1)
        begin
            env_phase = nxt;
            env_ofs   = 0;
        end
        else
            env_ofs++;
        return 1'b1;
    endfunction

    // Verdict word; an unmatched verdict carries nothing but its kind.
    function automatic jepp_pkg::result_t verdict_word(input bit hit);
        jepp_pkg::result_t w;
        w      = '0;
        w.kind = jepp_pkg::KIND_VERDICT;
        if (hit)
        begin
            w.matched    = 1'b1;
            w.opcode     = env_op;
            w.has_seq    = env_has_seq;
            w.seq_number = env_has_seq ? env_seq[jepp_pkg::SEQ_W-1:0] : '0;
            w.has_event  = env_named;
        end
        return w;
    endfunction

    // Advance the envelope parser by one byte and collect the words it causes.
    function automatic void parse_envelope_byte(input logic [7:0] b, input logic fin);
        jepp_pkg::result_t w;
        logic [63:0]       d;
        bit                ok;
        bit                dig;
        ok  = 1'b1;
        dig = (b >= "0") && (b <= "9");
        d   = 64'(b - "0");
        byte_words.delete();
        case (env_phase) inside
            jepp_pkg::PH_PRE:   ok = tag_step(TAG_T, 5, b, jepp_pkg::PH_TVAL);
            jepp_pkg::PH_TVAL:
            begin
                if (b == jepp_pkg::CH_N)
                begin
                    env_phase = jepp_pkg::PH_TNULL;
                    env_ofs   = 1;           // the n is already taken
                end
                else if (b == jepp_pkg::CH_QUOTE)
                    env_phase = jepp_pkg::PH_NAME0;
                else
                    ok = 1'b0;
            end
            jepp_pkg::PH_TNULL: ok = tag_step(TAG_NULL, 4, b, jepp_pkg::PH_SLIT);
            jepp_pkg::PH_NAME0, jepp_pkg::PH_NAME:
            begin
                if ((b >= "A" && b <= "Z") || b == "_" || dig)
                begin
                    w           = '0;
                    w.kind      = jepp_pkg::KIND_NAME;
                    w.name_char = b;
                    byte_words.push_back(w);
                    env_phase   = jepp_pkg::PH_NAME;
                end
                else if (b == jepp_pkg::CH_QUOTE && env_phase == jepp_pkg::PH_NAME)
                begin
                    env_named = 1'b1;
                    env_phase = jepp_pkg::PH_SLIT;
                    env_ofs   = 0;
                end
                else
                    ok = 1'b0;               // includes the empty name
            end
            jepp_pkg::PH_SLIT:  ok = tag_step(TAG_S, 5, b, jepp_pkg::PH_SVAL);
            jepp_pkg::PH_SVAL:
            begin
                if (b == jepp_pkg::CH_N)
                begin
                    env_phase = jepp_pkg::PH_SNULL;
                    env_ofs   = 1;
                end
                else if (dig)
                begin
                    env_seq   = d;
                    env_phase = jepp_pkg::PH_SDIG;
                end
                else
                    ok = 1'b0;
            end
            jepp_pkg::PH_SNULL: ok = tag_step(TAG_NULL, 4, b, jepp_pkg::PH_OLIT);
            jepp_pkg::PH_SDIG:
            begin
                if (dig)
                begin
                    if (env_seq > (SEQ_CEIL - d) / 10)
                        ok = 1'b0;           // would pass 2^63-1
                    else
                        env_seq = env_seq * 10 + d;
                end
                else if (b == jepp_pkg::CH_COMMA)
                begin
                    env_has_seq = 1'b1;
                    env_phase   = jepp_pkg::PH_OLIT;
                    env_ofs     = 1;         // comma doubles as the op tag's first byte
                end
                else
                    ok = 1'b0;
            end
            jepp_pkg::PH_OLIT:  ok = tag_step(TAG_OP, 6, b, jepp_pkg::PH_ODIG0);
            jepp_pkg::PH_ODIG0:
            begin
                if (dig)
                begin
                    env_op    = jepp_pkg::OP_W'(d);
                    env_phase = jepp_pkg::PH_ODIG;
                end
                else
                    ok = 1'b0;
            end
            jepp_pkg::PH_ODIG:
            begin
                if (dig)
                begin
                    if (env_op > jepp_pkg::OP_LIMIT)
                        ok = 1'b0;
                    else
                        env_op = jepp_pkg::OP_W'(env_op * 10 + d);
                end
                else
                begin
                    // any non-digit closes the op field and gives the verdict
                    byte_words.push_back(verdict_word(1'b1));
                    env_phase = jepp_pkg::PH_DONE;
                end
            end
            jepp_pkg::PH_DONE:  ;
            default:  ok = 1'b0;
        endcase

        if (!ok)
        begin
            env_phase = jepp_pkg::PH_DEAD;
            env_ofs   = 0;
        end

        if (fin)
        begin
            if (env_phase != jepp_pkg::PH_DONE)
                byte_words.push_back(verdict_word(env_phase == jepp_pkg::PH_ODIG));
            env_phase   = jepp_pkg::PH_PRE;
            env_ofs     = 0;
            env_seq     = '0;
            env_has_seq = 1'b0;
            env_named   = 1'b0;
            env_op      = '0;
        end

        if (byte_words.size() != 0)
        begin
            w            = byte_words.pop_back();
            w.end_of_run = 1'b1;
            byte_words.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one word and return at the edge that takes it.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_req <= b;
        last     <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic feed_byte(input logic [7:0] b, input logic fin);
        if (env_phase != jepp_pkg::PH_DONE)
            items_fed++;                     // bytes past a verdict do not count
        send_byte(b, fin);
        parse_envelope_byte(b, fin);
        foreach (byte_words[i])
            owed_words.push_back(byte_words[i]);
    endtask

    // Hold the sender idle until every owed word has come out.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_words.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Payload builders
    // ------------------------------------------------------------------
    task automatic push_tag(input logic [47:0] tag, input int len);
        for (int i = 0; i < len; i++)
            frame_q.push_back(tag[8*(len-1-i) +: 8]);
    endtask

    task automatic push_decimal(input logic [63:0] v);
        logic [7:0] digs[$];
        do
        begin
            digs.push_front(8'(v % 10) + "0");
            v = v / 10;
        end
        while (v != 0);
        foreach (digs[i])
            frame_q.push_back(digs[i]);
    endtask

    task automatic push_digits(input int n);
        repeat (n)
            frame_q.push_back(8'("0" + $urandom_range(9)));
    endtask

    // Mostly well-formed envelopes with random content; the rest is noise,
    // a flipped byte, or a cut-short payload.
    task automatic compose_frame();
        int pick;
        int cut;
        int k;
        frame_q.delete();
        pick = $urandom_range(99);
        if (pick >= 85)
        begin
            repeat ($urandom_range(1, 6))
                frame_q.push_back(8'($urandom_range(255)));
            return;
        end

        push_tag(TAG_T, 5);
        pick = $urandom_range(99);
        if (pick < 40)
            push_tag(TAG_NULL, 4);
        else
        begin
            frame_q.push_back(jepp_pkg::CH_QUOTE);
            if (pick < 92)                   // otherwise an empty name
            begin
                repeat ($urandom_range(1, 4))
                begin
                    k = $urandom_range(36);
                    if (k < 26)
                        frame_q.push_back(8'("A" + k));
                    else if (k < 36)
                        frame_q.push_back(8'("0" + k - 26));
                    else
                        frame_q.push_back("_");
                end
            end
            frame_q.push_back(jepp_pkg::CH_QUOTE);
        end

        push_tag(TAG_S, 5);
        pick = $urandom_range(99);
        if (pick < 35)
            push_tag(TAG_NULL, 4);
        else if (pick < 45)
            push_decimal(SEQ_CEIL);          // largest sequence
        else if (pick < 52)
            push_decimal(SEQ_CEIL + 1);      // one past, overflows on the last digit
        else if (pick < 58)
        begin
            push_decimal(SEQ_CEIL);
            push_digits(1);                  // twentieth digit always overflows
        end
        else
            push_digits($urandom_range(1, 6));

        push_tag(TAG_OP, 6);
        pick = $urandom_range(99);
        if (pick < 8)
            push_decimal(999);
        else if (pick < 22)
            push_digits(4);                  // fourth digit overflows when op > 99
        else
            push_digits($urandom_range(1, 3));

        // 40%: payload ends on the last op digit; else a closing byte plus junk
        if ($urandom_range(99) >= 40)
        begin
            frame_q.push_back(8'($urandom_range(255)));
            repeat ($urandom_range(0, 4))
                frame_q.push_back(8'($urandom_range(255)));
        end

        pick = $urandom_range(99);
        if (pick < 12)
            frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom_range(255));
        else if (pick < 24)
        begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, and checking of every word taken
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

    task automatic report_word(input string what, input jepp_pkg::result_t want,
                               input jepp_pkg::result_t got);
        faults++;
        if (faults <= MAX_REPORTS)
        begin
            $display("%0t %s", $time, what);
            $display("  exp kind=%0d ch=%02h m=%0d op=%0d hs=%0d seq=%0d he=%0d eor=%0d",
                     want.kind, want.name_char, want.matched, want.opcode, want.has_seq,
                     want.seq_number, want.has_event, want.end_of_run);
            $display("  got kind=%0d ch=%02h m=%0d op=%0d hs=%0d seq=%0d he=%0d eor=%0d",
                     got.kind, got.name_char, got.matched, got.opcode, got.has_seq,
                     got.seq_number, got.has_event, got.end_of_run);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_word            = '0;
            got_word.kind       = jepp_pkg::kind_t'(kind);
            got_word.name_char  = name_char;
            got_word.matched    = matched;
            got_word.opcode     = opcode;
            got_word.has_seq    = has_seq;
            got_word.seq_number = seq_number;
            got_word.has_event  = has_event;
            got_word.end_of_run = end_of_run;
            if (owed_words.size() == 0)
                report_word("word with nothing owed", '0, got_word);
            else
            begin
                want_word = owed_words.pop_front();
                if (got_word.kind       !== want_word.kind       ||
                    got_word.name_char  !== want_word.name_char  ||
                    got_word.matched    !== want_word.matched    ||
                    got_word.opcode     !== want_word.opcode     ||
                    got_word.has_seq    !== want_word.has_seq    ||
                    got_word.seq_number !== want_word.seq_number ||
                    got_word.has_event  !== want_word.has_event  ||
                    got_word.end_of_run !== want_word.end_of_run)
                    report_word("word mismatch", want_word, got_word);
            end
        end
    end

    // Watchdog: a long run of cycles with nothing moving means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        jepp_pkg::result_t pin;

        // directed table: bad first bytes at both byte extremes, a cut-short
        // prefix, then a full null/null envelope whose op digit is the last byte
        probes = '{
            '{8'h00, 1'b1, 1'b1, 1'b0, 10'd0},   // mismatch on first byte
            '{8'hFF, 1'b1, 1'b1, 1'b0, 10'd0},
            '{"{",   1'b1, 1'b1, 1'b0, 10'd0},   // truncated prefix
            '{"{",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"\"",  1'b0, 1'b0, 1'b0, 10'd0},
            '{"t",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"\"",  1'b0, 1'b0, 1'b0, 10'd0},
            '{":",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"n",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"u",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"l",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"l",   1'b0, 1'b0, 1'b0, 10'd0},
            '{",",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"\"",  1'b0, 1'b0, 1'b0, 10'd0},
            '{"s",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"\"",  1'b0, 1'b0, 1'b0, 10'd0},
            '{":",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"n",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"u",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"l",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"l",   1'b0, 1'b0, 1'b0, 10'd0},
            '{",",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"\"",  1'b0, 1'b0, 1'b0, 10'd0},
            '{"o",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"p",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"\"",  1'b0, 1'b0, 1'b0, 10'd0},
            '{":",   1'b0, 1'b0, 1'b0, 10'd0},
            '{"9",   1'b1, 1'b1, 1'b1, 10'd9}    // op digit on last byte
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (probes[i])
        begin
            send_byte(probes[i].data, probes[i].fin);
            parse_envelope_byte(probes[i].data, probes[i].fin);
            if (probes[i].pinned)
            begin
                pin            = '0;
                pin.kind       = jepp_pkg::KIND_VERDICT;
                pin.matched    = probes[i].pin_matched;
                pin.opcode     = probes[i].pin_opcode;
                pin.end_of_run = 1'b1;
                owed_words.push_back(pin);
            end
            else
            begin
                foreach (byte_words[j])
                    owed_words.push_back(byte_words[j]);
            end
        end

        // sender holds off until the block has emptied
        drain_outputs();

        while (items_fed < RANDOM_ITEMS)
        begin
            compose_frame();
            calm <= (frames_done >= 5) && (frames_done < 9);
            foreach (frame_q[i])
                feed_byte(frame_q[i], i == frame_q.size() - 1);
            frames_done++;
            if ($urandom_range(99) < 8)
                drain_outputs();
        end

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (faults == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
